[rtl/one_wire_master_slot_engine_assert.svh]
// Assertion macros for the 1-Wire slot engine.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ONE_WIRE_MASTER_SLOT_ENGINE_ASSERT_SVH
`define ONE_WIRE_MASTER_SLOT_ENGINE_ASSERT_SVH

// Property checked on every rising clock edge outside of reset.
`define OWM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define OWM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/owm_pkg.sv]
// Package for the 1-Wire slot engine: word types, phase and command codes,
// register indexes and reset values. No dependencies.
package owm_pkg;

	localparam int CFG_W = 12;
	localparam int TIMER_BITS_DEF = 12;
	localparam int NUM_REGS = 8;
	localparam int REG_IDX_W = 3;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_RESET = 2'd1,
		KIND_WRITE = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RESET_LOW     = 3'd0,
		REG_PRESENCE_DLY  = 3'd1,
		REG_RECOVERY      = 3'd2,
		REG_ZERO_LOW      = 3'd3,
		REG_ONE_LOW       = 3'd4,
		REG_SLOT          = 3'd5,
		REG_READ_LOW      = 3'd6,
		REG_READ_SMP_DLY  = 3'd7
	} reg_idx_t;

	localparam logic [CFG_W-1:0] RST_RESET_LOW    = 12'd1000;
	localparam logic [CFG_W-1:0] RST_PRESENCE_DLY = 12'd100;
	localparam logic [CFG_W-1:0] RST_RECOVERY     = 12'd480;
	localparam logic [CFG_W-1:0] RST_ZERO_LOW     = 12'd63;
	localparam logic [CFG_W-1:0] RST_ONE_LOW      = 12'd2;
	localparam logic [CFG_W-1:0] RST_SLOT         = 12'd65;
	localparam logic [CFG_W-1:0] RST_READ_LOW     = 12'd2;
	localparam logic [CFG_W-1:0] RST_READ_SMP_DLY = 12'd8;

	typedef enum logic [6:0] {
		PH_IDLE        = 7'b0000001,
		PH_RST_LOW     = 7'b0000010,
		PH_RST_SAMPLE  = 7'b0000100,
		PH_RST_HIGH    = 7'b0001000,
		PH_RST_RECOVER = 7'b0010000,
		PH_WRITE       = 7'b0100000,
		PH_READ        = 7'b1000000
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] write_byte;
		logic       line_level;
	} item_t;

	typedef struct packed {
		logic pull_low;
		logic busy_res;
		logic finished;
		logic device_present;
		logic bit_read;
		logic refused;
	} res_t;

endpackage

[rtl/one_wire_master_slot_engine.sv]
// 1-Wire bus master slot engine, top level.
// An accepted word sits in the input register; its result goes to the result buffer.
// One word per cycle unless stalled: the state update is one compare/increment pass.
// A two-entry result buffer lets input words keep flowing while a result waits.
// Reset (arst_n low, async): phase idle, counters and flags zero, registers at defaults.
// Stall on the input rises only when the input register and both result slots are full.
module one_wire_master_slot_engine
	import owm_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data
);

	// compare width covers both the timer and the register fields, plus one for e+1
	localparam int LW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam int EW = LW + 1;
	localparam logic [LW-1:0] TMAX = LW'((64'd1 << TIMER_BITS) - 64'd1);

	// ---------------- configuration registers ----------------
	logic [CFG_W-1:0] reset_low_q, presence_dly_q, recovery_q, zero_low_q;
	logic [CFG_W-1:0] one_low_q, slot_q, read_low_q, read_smp_dly_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q    <= RST_RESET_LOW;
			presence_dly_q <= RST_PRESENCE_DLY;
			recovery_q     <= RST_RECOVERY;
			zero_low_q     <= RST_ZERO_LOW;
			one_low_q      <= RST_ONE_LOW;
			slot_q         <= RST_SLOT;
			read_low_q     <= RST_READ_LOW;
			read_smp_dly_q <= RST_READ_SMP_DLY;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_RESET_LOW:    reset_low_q    <= wr_data;
				REG_PRESENCE_DLY: presence_dly_q <= wr_data;
				REG_RECOVERY:     recovery_q     <= wr_data;
				REG_ZERO_LOW:     zero_low_q     <= wr_data;
				REG_ONE_LOW:      one_low_q      <= wr_data;
				REG_SLOT:         slot_q         <= wr_data;
				REG_READ_LOW:     read_low_q     <= wr_data;
				REG_READ_SMP_DLY: read_smp_dly_q <= wr_data;
				default: ;
			endcase
		end
	end

	// ---------------- input register ----------------
	item_t item_s1;
	logic  valid_s1;
	logic  item_acc;
	logic  adv;
	logic  pop;
	logic [1:0] cnt_q;

	assign adv        = valid_s1 && (cnt_q != 2'd2);
	assign item_stall = valid_s1 && !adv;
	assign item_acc   = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			item_s1 <= item;
		end
	end

	// ---------------- engine state ----------------
	phase_t            phase_q, phase_n;
	logic [TIMER_BITS-1:0] elapsed_q, elapsed_n;
	logic [3:0]        bits_left_q, bits_left_n;
	logic [7:0]        shift_q, shift_n;
	logic              presence_q, presence_n;
	logic              sampled_q, sampled_n;
	logic              fin, refuse, pull;

	// register length clamped to the timer range
	function automatic logic [LW-1:0] clampt(input logic [CFG_W-1:0] len);
		logic [LW-1:0] l;
		l = LW'(len);
		return (l > TMAX) ? TMAX : l;
	endfunction

	logic [EW-1:0] e_inc;
	logic [LW-1:0] slot_len;
	logic [EW-1:0] smp_at;
	logic [EW-1:0] smp_sum;
	logic          end_rst_low, end_presence, end_recover, end_slot;
	logic [CFG_W-1:0] wr_low;

	assign e_inc        = EW'(elapsed_q) + EW'(1);
	assign end_rst_low  = e_inc >= EW'(clampt(reset_low_q));
	assign end_presence = e_inc >= EW'(clampt(presence_dly_q));
	assign end_recover  = e_inc >= EW'(clampt(recovery_q));
	assign end_slot     = e_inc >= EW'(clampt(slot_q));

	// read sample point: low + delay, pulled in to the last tick of the slot
	always_comb begin
		slot_len = clampt(slot_q);
		if (slot_len == '0) begin
			slot_len = LW'(1);
		end
		smp_sum = EW'(read_low_q) + EW'(read_smp_dly_q);
		smp_at  = (smp_sum > EW'(slot_len)) ? EW'(slot_len) : smp_sum;
	end

	always_comb begin
		phase_n     = phase_q;
		elapsed_n   = elapsed_q;
		bits_left_n = bits_left_q;
		shift_n     = shift_q;
		presence_n  = presence_q;
		sampled_n   = sampled_q;
		fin         = 1'b0;
		refuse      = 1'b0;
		if (item_s1.kind != KIND_TICK) begin
			if (phase_q != PH_IDLE) begin
				refuse = 1'b1;
			end else begin
				elapsed_n = '0;
				unique case (item_s1.kind)
					KIND_RESET: phase_n = PH_RST_LOW;
					KIND_WRITE: begin
						phase_n     = PH_WRITE;
						shift_n     = item_s1.write_byte;
						bits_left_n = 4'd8;
					end
					KIND_READ:  phase_n = PH_READ;
					default: ;
				endcase
			end
		end else begin
			unique case (phase_q)
				PH_RST_LOW: begin
					if (end_rst_low) begin
						phase_n   = PH_RST_SAMPLE;
						elapsed_n = '0;
					end else begin
						elapsed_n = elapsed_q + 1'b1;
					end
				end
				PH_RST_SAMPLE: begin
					if (end_presence) begin
						presence_n = !item_s1.line_level;
						phase_n    = item_s1.line_level ? PH_RST_RECOVER : PH_RST_HIGH;
						elapsed_n  = '0;
					end else begin
						elapsed_n = elapsed_q + 1'b1;
					end
				end
				PH_RST_HIGH: begin
					// no timeout here, elapsed holds
					if (item_s1.line_level) begin
						phase_n   = PH_RST_RECOVER;
						elapsed_n = '0;
					end
				end
				PH_RST_RECOVER: begin
					if (end_recover) begin
						phase_n   = PH_IDLE;
						elapsed_n = '0;
						fin       = 1'b1;
					end else begin
						elapsed_n = elapsed_q + 1'b1;
					end
				end
				PH_WRITE: begin
					if (end_slot) begin
						shift_n     = {1'b0, shift_q[7:1]};
						bits_left_n = bits_left_q - 4'd1;
						elapsed_n   = '0;
						if (bits_left_n == 4'd0) begin
							phase_n = PH_IDLE;
							fin     = 1'b1;
						end
					end else begin
						elapsed_n = elapsed_q + 1'b1;
					end
				end
				PH_READ: begin
					if (e_inc == smp_at) begin
						sampled_n = item_s1.line_level;
					end
					if (end_slot) begin
						phase_n   = PH_IDLE;
						elapsed_n = '0;
						fin       = 1'b1;
					end else begin
						elapsed_n = elapsed_q + 1'b1;
					end
				end
				default: begin
					phase_n   = PH_IDLE;
					elapsed_n = '0;
				end
			endcase
		end
	end

	// line drive from the state after this word
	assign wr_low = shift_n[0] ? one_low_q : zero_low_q;

	always_comb begin
		pull = 1'b0;
		priority case (phase_n)
			PH_RST_LOW: pull = 1'b1;
			PH_WRITE:   pull = LW'(elapsed_n) < LW'(wr_low);
			PH_READ:    pull = LW'(elapsed_n) < LW'(read_low_q);
			default:    pull = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			elapsed_q   <= '0;
			bits_left_q <= '0;
			shift_q     <= '0;
			presence_q  <= 1'b0;
			sampled_q   <= 1'b0;
		end else if (adv) begin
			phase_q     <= phase_n;
			elapsed_q   <= elapsed_n;
			bits_left_q <= bits_left_n;
			shift_q     <= shift_n;
			presence_q  <= presence_n;
			sampled_q   <= sampled_n;
		end
	end

	// ---------------- result buffer (two entries) ----------------
	res_t res_mem_q [2];
	res_t res_new;
	logic wr_ptr_q, rd_ptr_q;

	assign res_new = '{
		pull_low:       pull,
		busy_res:       phase_n != PH_IDLE,
		finished:       fin,
		device_present: presence_n,
		bit_read:       sampled_n,
		refused:        refuse
	};

	assign res_valid = cnt_q != 2'd0;
	assign res       = res_mem_q[rd_ptr_q];
	assign pop       = res_valid && !res_stall;

	always_ff @(posedge clk) begin
		if (adv) begin
			res_mem_q[wr_ptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (adv) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(adv) - 2'(pop);
		end
	end

	// ---------------- checks ----------------
`include "one_wire_master_slot_engine_assert.svh"

	`OWM_ASSERT(a_idle_timer_clear, (phase_q == PH_IDLE) |-> (elapsed_q == '0), "timer not clear in idle")
	`OWM_ASSERT(a_write_bits, (phase_q == PH_WRITE) |-> (bits_left_q != 4'd0 && bits_left_q <= 4'd8), "bit count out of range in write")
	`OWM_ASSERT(a_refused_busy, (res_valid && res.refused) |-> res.busy_res, "refused word reports idle")
	`OWM_ASSERT(a_finished_idle, (res_valid && res.finished) |-> (!res.busy_res && !res.pull_low), "finished word still busy or pulling")
	`OWM_ASSERT_ALWAYS(a_stall_full, item_stall |-> (cnt_q == 2'd2), "input stalled with buffer room")

endmodule

[tb/one_wire_master_slot_engine_chk.sv]
// Checker for the 1-Wire slot engine: tracks the slot timing from every accepted
// input word and compares each result word, in order, field by field.
// Depends on owm_pkg for the word types, the phase and register codes and the defaults.
module one_wire_master_slot_engine_chk
	import owm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_stall,
	input  item_t                item,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  res_t                 res,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output int                   err_count,
	output int                   words_due
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CFG_W-1:0] tcfg [NUM_REGS];
	phase_t           ph;
	logic [CFG_W-1:0] el;
	logic [3:0]       bits_left;
	logic [7:0]       sh;
	logic             pres;
	logic             smp;
	res_t             due_words [$];
	int               errs;

	// Phase of length len ends on this tick; a length of 0 acts as 1.
	function automatic logic ends(logic [CFG_W-1:0] len);
		return ({1'b0, el} + 13'd1) >= {1'b0, len};
	endfunction

	function automatic res_t next_bus_word(item_t w);
		res_t             r;
		logic [CFG_W:0]   slot;
		logic [CFG_W:0]   at;
		logic [CFG_W-1:0] lt;
		logic             fin;
		r = '0;
		fin = 1'b0;
		if (w.kind != KIND_TICK) begin
			if (ph != PH_IDLE) begin
				r.refused = 1'b1;
			end else begin
				el = '0;
				case (w.kind)
					KIND_RESET: ph = PH_RST_LOW;
					KIND_WRITE: begin
						ph = PH_WRITE;
						sh = w.write_byte;
						bits_left = 4'd8;
					end
					default: ph = PH_READ;
				endcase
			end
		end else begin
			case (ph)
				PH_RST_LOW: begin
					if (ends(tcfg[REG_RESET_LOW])) begin
						ph = PH_RST_SAMPLE;
						el = '0;
					end else el = el + 1'b1;
				end
				PH_RST_SAMPLE: begin
					if (ends(tcfg[REG_PRESENCE_DLY])) begin
						pres = !w.line_level;
						ph = w.line_level ? PH_RST_RECOVER : PH_RST_HIGH;
						el = '0;
					end else el = el + 1'b1;
				end
				PH_RST_HIGH: begin
					// no timeout, elapsed held
					if (w.line_level) begin
						ph = PH_RST_RECOVER;
						el = '0;
					end
				end
				PH_RST_RECOVER: begin
					if (ends(tcfg[REG_RECOVERY])) begin
						ph = PH_IDLE;
						el = '0;
						fin = 1'b1;
					end else el = el + 1'b1;
				end
				PH_WRITE: begin
					if (ends(tcfg[REG_SLOT])) begin
						sh = sh >> 1;
						bits_left = bits_left - 1'b1;
						el = '0;
						if (bits_left == 4'd0) begin
							ph = PH_IDLE;
							fin = 1'b1;
						end
					end else el = el + 1'b1;
				end
				PH_READ: begin
					// sample point clamped to the last tick of the slot
					slot = {1'b0, tcfg[REG_SLOT]};
					if (slot == '0) slot = (CFG_W+1)'(1);
					at = {1'b0, tcfg[REG_READ_LOW]} + {1'b0, tcfg[REG_READ_SMP_DLY]};
					if (at > slot) at = slot;
					if (({1'b0, el} + 13'd1) == at) smp = w.line_level;
					if (ends(tcfg[REG_SLOT])) begin
						ph = PH_IDLE;
						el = '0;
						fin = 1'b1;
					end else el = el + 1'b1;
				end
				default: begin
					ph = PH_IDLE;
					el = '0;
				end
			endcase
		end

		case (ph)
			PH_RST_LOW: r.pull_low = 1'b1;
			PH_WRITE: begin
				lt = sh[0] ? tcfg[REG_ONE_LOW] : tcfg[REG_ZERO_LOW];
				r.pull_low = el < lt;
			end
			PH_READ: r.pull_low = el < tcfg[REG_READ_LOW];
			default: r.pull_low = 1'b0;
		endcase
		r.busy_res = ph != PH_IDLE;
		r.finished = fin;
		r.device_present = pres;
		r.bit_read = smp;
		return r;
	endfunction

	task automatic check_field(string nm, logic e, logic a);
		if (a !== e) begin
			$display("%0t: %s mismatch, expected %b actual %b", $time, nm, e, a);
			errs++;
		end
	endtask

	always @(posedge clk) begin : watch
		res_t exp_w;
		if (!arst_n) begin
			tcfg[REG_RESET_LOW] = RST_RESET_LOW;
			tcfg[REG_PRESENCE_DLY] = RST_PRESENCE_DLY;
			tcfg[REG_RECOVERY] = RST_RECOVERY;
			tcfg[REG_ZERO_LOW] = RST_ZERO_LOW;
			tcfg[REG_ONE_LOW] = RST_ONE_LOW;
			tcfg[REG_SLOT] = RST_SLOT;
			tcfg[REG_READ_LOW] = RST_READ_LOW;
			tcfg[REG_READ_SMP_DLY] = RST_READ_SMP_DLY;
			ph = PH_IDLE;
			el = '0;
			bits_left = '0;
			sh = '0;
			pres = 1'b0;
			smp = 1'b0;
			due_words.delete();
			errs = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (due_words.size() == 0) begin
					$display("%0t: result word with none expected, actual %b", $time, res);
					errs++;
				end else begin
					exp_w = due_words.pop_front();
					check_field("pull_low", exp_w.pull_low, res.pull_low);
					check_field("busy_res", exp_w.busy_res, res.busy_res);
					check_field("finished", exp_w.finished, res.finished);
					check_field("device_present", exp_w.device_present, res.device_present);
					check_field("bit_read", exp_w.bit_read, res.bit_read);
					check_field("refused", exp_w.refused, res.refused);
				end
			end
			if (wr_en) tcfg[wr_index] = wr_data;
			if (item_valid && !item_stall) due_words.push_back(next_bus_word(item));
		end
		err_count <= errs;
		words_due <= due_words.size();
	end

endmodule

[tb/one_wire_master_slot_engine_tb.sv]
// Testbench top for the 1-Wire slot engine: clock, reset, register loads and
// input words; the checker module does all prediction. Needs owm_pkg, the engine
// and one_wire_master_slot_engine_chk.
module one_wire_master_slot_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import owm_pkg::*;

	// Far above the slowest legal run (every word with the longest gap and stall).
	localparam int CYCLE_LIMIT = 3_000_000;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	item_t                item;
	logic                 res_valid;
	logic                 res_stall;
	res_t                 res;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;
	int                   err_count;
	int                   words_due;

	int                   cycle_count = 0;
	int                   words_sent = 0;
	int                   calm_left = 0;
	logic                 last_busy = 1'b0;
	// registers as last loaded, used to size the tick runs
	logic [CFG_W-1:0]     regs_now [NUM_REGS];
	logic [CFG_W-1:0]     plan [NUM_REGS];

	one_wire_master_slot_engine u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data)
	);

	one_wire_master_slot_engine_chk u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.err_count  (err_count),
		.words_due  (words_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// busy flag of the newest result word, used to drain before a register load
	always @(posedge clk) begin
		if (res_valid && !res_stall) last_busy <= res.busy_res;
	end

	// Watchdog: a hung engine or a lost result word ends here.
	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("one_wire_master_slot_engine_tb: done, errors");
		$finish;
	end

	// Result side: open stretches, mostly short stalls, now and then a long one.
	initial begin : res_side
		int run;
		int hold;
		res_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
			repeat (run) @(negedge clk) res_stall <= 1'b0;
			hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3);
			repeat (hold) @(negedge clk) res_stall <= 1'b1;
		end
	end

	function automatic item_t mk(kind_t k, logic [7:0] b, logic lvl);
		item_t w;
		w.kind = k;
		w.write_byte = b;
		w.line_level = lvl;
		return w;
	endfunction

	// Length of a timed phase as the engine counts it: 0 behaves like 1.
	function automatic int span(reg_idx_t r);
		return (regs_now[r] == '0) ? 1 : int'(regs_now[r]);
	endfunction

	// Drive one word at the falling edge, hold it until taken, then maybe idle.
	// With no gap, valid just stays high into the next word.
	task automatic send_word(item_t w);
		int gap;
		int pick;
		@(negedge clk);
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (item_stall);
		words_sent++;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 100);
			pick = $urandom_range(0, 19);
			gap = (pick == 0) ? $urandom_range(6, 20) : (pick < 10) ? 0 : $urandom_range(1, 3);
		end
		if (gap > 0) begin
			@(negedge clk) item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Writes the plan into all registers on back-to-back cycles.
	task automatic load_regs();
		for (int i = 0; i < NUM_REGS; i++) begin
			@(negedge clk);
			wr_en <= 1'b1;
			wr_index <= i[REG_IDX_W-1:0];
			wr_data <= plan[i];
			regs_now[i] = plan[i];
		end
		@(negedge clk) wr_en <= 1'b0;
	endtask

	task automatic set_plan(int rlow, int pdly, int rec, int zlow, int olow, int slot,
			int rdlow, int rsmp);
		plan[REG_RESET_LOW] = rlow[CFG_W-1:0];
		plan[REG_PRESENCE_DLY] = pdly[CFG_W-1:0];
		plan[REG_RECOVERY] = rec[CFG_W-1:0];
		plan[REG_ZERO_LOW] = zlow[CFG_W-1:0];
		plan[REG_ONE_LOW] = olow[CFG_W-1:0];
		plan[REG_SLOT] = slot[CFG_W-1:0];
		plan[REG_READ_LOW] = rdlow[CFG_W-1:0];
		plan[REG_READ_SMP_DLY] = rsmp[CFG_W-1:0];
		load_regs();
	endtask

	// One command and the ticks it needs.
	//   present  : line low at the presence sample (reset only)
	//   hold_low : extra low ticks before the line comes back high
	//   extra    : ticks beyond (or short of, if negative) the sequence length
	//   poke     : tick index where a refused command is slipped in, -1 for none
	task automatic run_cmd(kind_t k, logic [7:0] b, bit present, int hold_low, int extra,
			int poke);
		int   n;
		int   lead;
		logic lvl;
		lead = span(REG_RESET_LOW) + span(REG_PRESENCE_DLY);
		send_word(mk(k, b, 1'($urandom)));
		case (k)
			KIND_RESET: n = lead + (present ? hold_low + 1 : 0) + span(REG_RECOVERY);
			KIND_WRITE: n = 8 * span(REG_SLOT);
			default: n = span(REG_SLOT);
		endcase
		n = n + extra;
		for (int i = 0; i < n; i++) begin
			if (i == poke) send_word(mk(kind_t'($urandom_range(1, 3)), 8'($urandom),
				1'($urandom)));
			// level only matters from the presence sample on
			if (k != KIND_RESET || i < span(REG_RESET_LOW)) lvl = 1'($urandom);
			else lvl = !(present && i < lead + hold_low);
			send_word(mk(KIND_TICK, 8'($urandom), lvl));
		end
	endtask

	// Tick with the line high until every result is in and the engine reports idle.
	task automatic settle();
		bit more;
		more = 1'b1;
		while (more) begin
			@(negedge clk) item_valid <= 1'b0;
			wait (words_due == 0);
			if (last_busy) repeat (64) send_word(mk(KIND_TICK, 8'($urandom), 1'b1));
			else more = 1'b0;
		end
	endtask

	initial begin : stim
		int pick;
		int mark;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		regs_now[REG_RESET_LOW] = RST_RESET_LOW;
		regs_now[REG_PRESENCE_DLY] = RST_PRESENCE_DLY;
		regs_now[REG_RECOVERY] = RST_RECOVERY;
		regs_now[REG_ZERO_LOW] = RST_ZERO_LOW;
		regs_now[REG_ONE_LOW] = RST_ONE_LOW;
		regs_now[REG_SLOT] = RST_SLOT;
		regs_now[REG_READ_LOW] = RST_READ_LOW;
		regs_now[REG_READ_SMP_DLY] = RST_READ_SMP_DLY;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Defaults out of reset: idle ticks do nothing, a read slot with a command
		// refused early in the slot.
		send_word(mk(KIND_TICK, 8'h00, 1'b0));
		send_word(mk(KIND_TICK, 8'hFF, 1'b1));
		run_cmd(KIND_READ, 8'h00, 1'b0, 0, 0, 5);
		settle();

		// Short timings: presence with a wait for the line, no presence (recovery at
		// once), write bytes at the extremes, a read sampled inside the slot.
		set_plan(3, 2, 4, 5, 1, 6, 2, 3);
		run_cmd(KIND_RESET, 8'h00, 1'b1, 4, 0, 2);
		run_cmd(KIND_RESET, 8'hFF, 1'b0, 0, 0, -1);
		run_cmd(KIND_WRITE, 8'h00, 1'b0, 0, 0, 7);
		run_cmd(KIND_WRITE, 8'hFF, 1'b0, 0, 0, -1);
		run_cmd(KIND_WRITE, 8'h5A, 1'b0, 0, 2, -1);
		run_cmd(KIND_READ, 8'h00, 1'b0, 0, 0, -1);
		run_cmd(KIND_READ, 8'hFF, 1'b0, 0, 0, -1);
		settle();

		// Low time at or past the slot, and a late read sample clamped to the slot end.
		set_plan(2, 1, 1, 4095, 7, 5, 3, 6);
		run_cmd(KIND_WRITE, 8'hC3, 1'b0, 0, 0, -1);
		run_cmd(KIND_READ, 8'h00, 1'b0, 0, 0, -1);
		run_cmd(KIND_RESET, 8'h00, 1'b1, 0, 0, -1);
		settle();

		// All zero: every timed phase ends on its first tick.
		set_plan(0, 0, 0, 0, 0, 0, 0, 0);
		run_cmd(KIND_RESET, 8'h00, 1'b1, 1, 0, -1);
		run_cmd(KIND_WRITE, 8'h81, 1'b0, 0, 0, -1);
		run_cmd(KIND_READ, 8'h00, 1'b0, 0, 1, -1);
		settle();

		// Smallest legal settings.
		set_plan(1, 1, 1, 1, 1, 2, 1, 1);
		run_cmd(KIND_RESET, 8'h00, 1'b0, 0, 0, -1);
		run_cmd(KIND_WRITE, 8'h69, 1'b0, 0, 0, -1);
		run_cmd(KIND_READ, 8'h00, 1'b0, 0, 0, 0);
		settle();

		// Largest settings around a short slot: low times far past the slot and the
		// widest sample point, clamped to the last tick.
		set_plan(4095, 4095, 4095, 4095, 4095, 2, 4095, 4095);
		run_cmd(KIND_WRITE, 8'hA5, 1'b0, 0, 0, -1);
		run_cmd(KIND_READ, 8'h00, 1'b0, 0, 0, -1);
		settle();

		// Random part: small timings so sequences are short, mostly well-formed
		// commands with random content, some cut short or overrun, some refused
		// commands mid-sequence, a few stray words.
		for (int p = 0; p < 10; p++) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				pick = $urandom_range(0, 9);
				if (pick < 6) plan[i] = CFG_W'($urandom_range(1, 12));
				else if (pick < 8) plan[i] = CFG_W'($urandom_range(13, 40));
				else if (pick == 8) plan[i] = CFG_W'(1);
				else plan[i] = CFG_W'($urandom_range(41, 100));
			end
			if (plan[REG_SLOT] < 2) plan[REG_SLOT] = CFG_W'(2);
			load_regs();
			mark = words_sent;
			while (words_sent - mark < 110) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					send_word(mk(kind_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom)));
				end else begin
					run_cmd(kind_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom),
						$urandom_range(0, 6),
						($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 6)) - 2 : 0,
						($urandom_range(0, 6) == 0) ? int'($urandom_range(0, 3)) : -1);
				end
			end
			settle();
		end

		// Everything answered; let any stray result words show before the final check.
		repeat (10) @(posedge clk);
		if (err_count == 0) begin
			$display("one_wire_master_slot_engine_tb: done, clean");
		end else begin
			$display("one_wire_master_slot_engine_tb: done, errors");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/owm_pkg.sv
rtl/one_wire_master_slot_engine.sv
tb/one_wire_master_slot_engine_chk.sv
tb/one_wire_master_slot_engine_tb.sv
